// File: rtl/core/bspq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_pkg: shared types and codes for the bounded stable priority queue
// Word layouts of both channels, the held entry, status codes and the
// per-cell control word.
// ----------------------------------------------------------------------------
package bspq_pkg;

  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned STAT_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic             mode;
    logic [ID_W-1:0]  req_id;
    logic [KEY_W-1:0] priority_key;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  out_id;
    logic [KEY_W-1:0] out_key;
    logic [CNT_W-1:0] occupancy;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    logic     occupied;
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/bounded_stable_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_stable_priority_queue: sorted queue built as a chain of cells
// Entries stay in ascending key order, ties in arrival order. Insert
// drops when full, remove pops the head. One result word per input word.
// ----------------------------------------------------------------------------
//  channel  ports                         word
//  in       in_valid / in_ready           in_data  (mode, req_id, priority_key)
//  out      out_valid / out_ready         out_data (status, id, key, occupancy)
//  cfg      cfg_valid / cfg_ready         cfg_data (capacity)
//
//  One word per cycle: all cells compare against the new key in parallel
//  and shift by one slot in the same edge; the result register sets the pace.
//  The result is registered and appears in the cycle after the input word is accepted.
//  in_ready drops only while a result waits and out_ready is low.
//  Reset empties the queue and sets capacity to 16; cfg_ready is always high.
// ----------------------------------------------------------------------------
module bounded_stable_priority_queue
  import bspq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int unsigned DEP_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (DEP_W > CNT_W) ? DEP_W : CNT_W;

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  out_word_t        out_data_r, out_data_nxt;

  logic             in_fire;
  logic [CMP_W-1:0] eff_cap;
  logic             full, empty;
  logic             do_insert, do_remove;

  entry_t           new_entry;
  entry_t           cell_entry [DEPTH];
  logic             cell_past  [DEPTH];
  cell_ctl_t        cell_ctl   [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign eff_cap = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign full    = CMP_W'(count_r) >= eff_cap;
  assign empty   = (count_r == '0);

  assign do_insert = in_fire && (in_data.mode == MODE_INSERT) && !full;
  assign do_remove = in_fire && (in_data.mode == MODE_REMOVE) && !empty;

  assign new_entry.id  = in_data.req_id;
  assign new_entry.key = in_data.priority_key;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_in, right_in;
    logic   left_past;

    if (i == 0) begin : g_first
      assign left_in   = '0;
      assign left_past = 1'b0;
    end else begin : g_mid
      assign left_in   = cell_entry[i-1];
      assign left_past = cell_past[i-1];
    end

    // the last cell's right input is never read back: that slot leaves use
    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner
      assign right_in = cell_entry[i+1];
    end

    always_comb begin
      cell_ctl[i].occupied = CMP_W'(i) < CMP_W'(count_r);
      priority if (do_insert && left_past) begin
        cell_ctl[i].op = CELL_FROM_LEFT;
      end else if (do_insert && cell_past[i]) begin
        cell_ctl[i].op = CELL_LOAD;
      end else if (do_remove) begin
        cell_ctl[i].op = CELL_FROM_RIGHT;
      end else begin
        cell_ctl[i].op = CELL_HOLD;
      end
    end

    bspq_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .new_entry   (new_entry),
      .left_entry  (left_in),
      .right_entry (right_in),
      .entry       (cell_entry[i]),
      .past        (cell_past[i])
    );
  end

  always_comb begin
    count_nxt    = count_r;
    out_data_nxt = out_data_r;
    if (in_fire) begin
      out_data_nxt.out_id  = '0;
      out_data_nxt.out_key = '0;
      if (in_data.mode == MODE_INSERT) begin
        if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          out_data_nxt.status = ST_INSERTED;
          count_nxt           = count_r + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          out_data_nxt.status  = ST_REMOVED;
          out_data_nxt.out_id  = cell_entry[0].id;
          out_data_nxt.out_key = cell_entry[0].key;
          count_nxt            = count_r - CNT_W'(1);
        end
      end
      out_data_nxt.occupancy = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    out_data_r <= out_data_nxt;
  end

  // occupancy never passes the built depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("queue count beyond depth");

  // an accepted word always leaves a result waiting
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted word produced no result");

  // a pop reports the removed status and shrinks the queue by one
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_remove |=> (out_data_r.status == ST_REMOVED) &&
                  (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop count mismatch");

  // a dropped insert leaves the queue as it was
  a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.mode == MODE_INSERT) && full) |=>
      (out_data_r.status == ST_FULL) && $stable(count_r))
    else $error("dropped insert changed count");

endmodule

`default_nettype wire

// File: rtl/core/bspq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bspq_cell: one slot of the sorted chain
// Holds one entry, flags whether an incoming key belongs at or before it,
// and loads from the broadcast entry or a neighbor as told.
// ----------------------------------------------------------------------------
module bspq_cell
  import bspq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    new_entry,
  input  wire entry_t    left_entry,
  input  wire entry_t    right_entry,
  output entry_t         entry,
  output logic           past
);

  entry_t entry_r;
  entry_t entry_nxt;

  // empty slot or strictly larger key: the new word goes here or earlier
  assign past  = !ctl.occupied || (entry_r.key > new_entry.key);
  assign entry = entry_r;

  always_comb begin
    unique case (ctl.op)
      CELL_LOAD:       entry_nxt = new_entry;
      CELL_FROM_LEFT:  entry_nxt = left_entry;
      CELL_FROM_RIGHT: entry_nxt = right_entry;
      default:         entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire
